// File: hw/rtl/shsc_pkg.sv
`default_nettype none
package shsc_pkg;

    // Stream widths: fields packed from bit 0 up, tdata widths padded to whole bytes
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 6;
    localparam int M_TDATA_W = 144;

    // Configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_X_THRESHOLD      = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ENERGY_THRESHOLD = 1'd1;
    localparam logic [15:0] X_THRESHOLD_RST      = 16'd0;
    localparam logic [15:0] ENERGY_THRESHOLD_RST = 16'd150;

    // Request kinds
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Detectors
    localparam logic [1:0] DET_X = 2'd0;
    localparam logic [1:0] DET_Y = 2'd1;
    localparam logic [1:0] DET_E = 2'd2;

    // Table selects
    localparam logic [2:0] TBL_X_OFFSET    = 3'd0;
    localparam logic [2:0] TBL_X_GAIN      = 3'd1;
    localparam logic [2:0] TBL_Y_OFFSET    = 3'd2;
    localparam logic [2:0] TBL_Y_GAIN      = 3'd3;
    localparam logic [2:0] TBL_Y_THRESHOLD = 3'd4;
    localparam logic [2:0] TBL_PEDESTAL    = 3'd5;
    localparam logic [2:0] TBL_E_GAIN      = 3'd6;

    // Channel code reported when multiplicity is not one
    localparam logic [4:0] CHAN_NONE = 5'b11111;

    typedef struct packed {
        logic        single;
        logic [3:0]  ch;
        logic [15:0] amp;
    } det_snap_t;

    typedef struct packed {
        det_snap_t x;
        det_snap_t y;
        det_snap_t e;
    } ev_snap_t;

    typedef struct packed {
        logic        en;
        logic [2:0]  sel;
        logic [3:0]  ch;
        logic [31:0] word;
    } tbl_wr_t;

    // Default Y thresholds per channel
    function automatic logic [15:0] y_thr_reset(input logic [3:0] ch);
        logic [15:0] r;
        case (ch)
            4'd0:  r = 16'd80;
            4'd1:  r = 16'd103;
            4'd2:  r = 16'd81;
            4'd3:  r = 16'd106;
            4'd4:  r = 16'd105;
            4'd5:  r = 16'd112;
            4'd6:  r = 16'd97;
            4'd7:  r = 16'd108;
            4'd8:  r = 16'd111;
            4'd9:  r = 16'd116;
            4'd10: r = 16'd116;
            4'd11: r = 16'd110;
            4'd12: r = 16'd110;
            4'd13: r = 16'd113;
            4'd14: r = 16'd98;
            4'd15: r = 16'd99;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/single_hit_strip_calibrator.sv
// A closing sample (last = 1) reaches m_tvalid through the input register and stages A to D.
// Throughput: one request per cycle; the input stalls only when the four-stage result
// pipeline is full and m_tready is low, and then only while the held request closes an event.
// Reset (aresetn low, synchronous): clears event counts, restores both thresholds and
// the Y threshold table defaults; gain, offset and pedestal tables stay undefined until written.
`default_nettype none
module single_hit_strip_calibrator import shsc_pkg::*; #(
    parameter int CHANNELS  = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // configuration: 0 x_threshold, 1 energy_threshold
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // channel[3:0], amplitude[19:4], table_word[51:20], zero pad [55:52]
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // op[0], table_select[3:1], detector[5:4]
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    input  wire logic                  s_tlast,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // x_channel[4:0], x_position[36:5], y_channel[41:37], y_amplitude[57:42],
    // y_position[89:58], e_channel[94:90], e_amplitude[110:95], e_energy[142:111],
    // zero pad [143]
    output logic [M_TDATA_W-1:0]       m_tdata
);

    // Front end: input register, hit decision and per-detector multiplicity.
    // Table writes leave here straight from the input register, so a table word is
    // always in place before any later event reads it.
    logic     snap_valid;
    logic     snap_ready;
    ev_snap_t snap;
    tbl_wr_t  tbl_wr;

    shsc_hit #(
        .CHANNELS (CHANNELS)
    ) u_hit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .snap_ready  (snap_ready),
        .snap_valid  (snap_valid),
        .snap        (snap),
        .tbl_wr      (tbl_wr)
    );

    // Back end, one step per stage: table read; products and the energy difference;
    // offset sums and energy gain products; floor, saturate and pack. Each stage holds
    // while the one after it is full and stalled; the last stage is the output register.
    shsc_cal #(
        .CHANNELS  (CHANNELS),
        .FRAC_BITS (FRAC_BITS)
    ) u_cal (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tbl_wr     (tbl_wr),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (snap_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
`default_nettype wire

// File: hw/rtl/shsc_ram.sv
`default_nettype none
module shsc_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                             aclk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                 wr_data,
    input  wire logic                             rd_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: hw/rtl/shsc_hit.sv
`default_nettype none
module shsc_hit import shsc_pkg::*; #(
    parameter int CHANNELS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    input  wire logic                  s_tlast,
    input  wire logic                  snap_ready,
    output logic                       snap_valid,
    output ev_snap_t                   snap,
    output tbl_wr_t                    tbl_wr
);

    localparam int AW = $clog2(CHANNELS > 1 ? CHANNELS : 2);

    logic [15:0] x_thr_reg;
    logic [15:0] e_thr_reg;

    logic        s_v_reg;
    logic        s_op_reg;
    logic [2:0]  s_sel_reg;
    logic [1:0]  s_det_reg;
    logic [3:0]  s_ch_reg;
    logic [15:0] s_amp_reg;
    logic [31:0] s_word_reg;
    logic        s_last_reg;

    logic [CHANNELS-1:0] thr_vld_reg;
    logic        thr_byp_reg;
    logic [15:0] thr_byp_val_reg;
    logic        thr_vld_s_reg;
    logic [15:0] thr_rd;

    logic [1:0]  cnt_reg [3];
    logic [3:0]  ch_reg  [3];
    logic [15:0] amp_reg [3];
    logic [1:0]  cnt_next [3];

    logic        accept;
    logic        consume;
    logic        s_close;
    logic        s_in_range;
    logic        in_range_in;
    logic [3:0]  in_ch;
    logic [AW-1:0] in_idx;
    logic [AW-1:0] s_idx;
    logic        thr_we;
    logic [15:0] y_thr;
    logic [2:0]  hit;
    logic        sample;

    assign in_ch       = s_tdata[3:0];
    assign in_idx      = AW'(in_ch);
    assign s_idx       = AW'(s_ch_reg);
    assign in_range_in = int'(in_ch) < CHANNELS;
    assign s_in_range  = int'(s_ch_reg) < CHANNELS;

    // a sample with last closes the event and needs a free snapshot slot
    assign s_close  = (s_op_reg == OP_SAMPLE) && s_last_reg;
    assign s_tready = !s_v_reg || !s_close || snap_ready;
    assign consume  = s_v_reg && s_tready;
    assign accept   = s_tvalid && s_tready;
    assign sample   = consume && (s_op_reg == OP_SAMPLE);

    assign thr_we = consume && (s_op_reg == OP_WRITE) && (s_sel_reg == TBL_Y_THRESHOLD)
                    && s_in_range;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_thr_reg <= X_THRESHOLD_RST;
            e_thr_reg <= ENERGY_THRESHOLD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_X_THRESHOLD:      x_thr_reg <= cfg_wr_data;
                REG_ENERGY_THRESHOLD: e_thr_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_v_reg <= 1'b0;
        end else if (accept) begin
            s_v_reg <= 1'b1;
        end else if (consume) begin
            s_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s_op_reg   <= s_tuser[0];
            s_sel_reg  <= s_tuser[3:1];
            s_det_reg  <= s_tuser[5:4];
            s_ch_reg   <= in_ch;
            s_amp_reg  <= s_tdata[19:4];
            s_word_reg <= s_tdata[51:20];
            s_last_reg <= s_tlast;
            // forward a threshold write that lands at this same edge
            thr_byp_reg     <= thr_we && (s_ch_reg == in_ch);
            thr_byp_val_reg <= s_word_reg[15:0];
            thr_vld_s_reg   <= in_range_in && thr_vld_reg[in_idx];
        end
    end

    // per-channel Y thresholds; unwritten entries read as their defaults
    shsc_ram #(
        .DEPTH (CHANNELS),
        .WIDTH (16)
    ) u_y_thr_ram (
        .aclk    (aclk),
        .wr_en   (thr_we),
        .wr_addr (s_idx),
        .wr_data (s_word_reg[15:0]),
        .rd_en   (accept),
        .rd_addr (in_idx),
        .rd_data (thr_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_vld_reg <= '0;
        end else if (thr_we) begin
            thr_vld_reg[s_idx] <= 1'b1;
        end
    end

    always_comb begin
        if (thr_byp_reg) begin
            y_thr = thr_byp_val_reg;
        end else if (thr_vld_s_reg) begin
            y_thr = thr_rd;
        end else begin
            y_thr = y_thr_reset(s_ch_reg);
        end
    end

    always_comb begin
        hit[DET_X] = s_in_range && (s_det_reg == DET_X) && (s_amp_reg > x_thr_reg);
        hit[DET_Y] = s_in_range && (s_det_reg == DET_Y) && (s_amp_reg > y_thr);
        hit[DET_E] = s_in_range && (s_det_reg == DET_E) && (s_amp_reg > e_thr_reg);
        for (int d = 0; d < 3; d++) begin
            if (hit[d]) begin
                cnt_next[d] = (cnt_reg[d] == 2'd2) ? 2'd2 : cnt_reg[d] + 2'd1;
            end else begin
                cnt_next[d] = cnt_reg[d];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < 3; d++) begin
                cnt_reg[d] <= 2'd0;
            end
        end else if (sample) begin
            for (int d = 0; d < 3; d++) begin
                cnt_reg[d] <= s_last_reg ? 2'd0 : cnt_next[d];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int d = 0; d < 3; d++) begin
            if (sample && hit[d]) begin
                ch_reg[d]  <= s_ch_reg;
                amp_reg[d] <= s_amp_reg;
            end
        end
    end

    // snapshot includes the closing sample itself
    always_comb begin
        snap_valid    = sample && s_last_reg;
        snap.x.single = (cnt_next[DET_X] == 2'd1);
        snap.x.ch     = hit[DET_X] ? s_ch_reg : ch_reg[DET_X];
        snap.x.amp    = hit[DET_X] ? s_amp_reg : amp_reg[DET_X];
        snap.y.single = (cnt_next[DET_Y] == 2'd1);
        snap.y.ch     = hit[DET_Y] ? s_ch_reg : ch_reg[DET_Y];
        snap.y.amp    = hit[DET_Y] ? s_amp_reg : amp_reg[DET_Y];
        snap.e.single = (cnt_next[DET_E] == 2'd1);
        snap.e.ch     = hit[DET_E] ? s_ch_reg : ch_reg[DET_E];
        snap.e.amp    = hit[DET_E] ? s_amp_reg : amp_reg[DET_E];
    end

    always_comb begin
        tbl_wr.en   = consume && (s_op_reg == OP_WRITE) && s_in_range;
        tbl_wr.sel  = s_sel_reg;
        tbl_wr.ch   = s_ch_reg;
        tbl_wr.word = s_word_reg;
    end

endmodule
`default_nettype wire

// File: hw/rtl/shsc_cal.sv
`default_nettype none
module shsc_cal import shsc_pkg::*; #(
    parameter int CHANNELS  = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire tbl_wr_t              tbl_wr,
    input  wire logic                 snap_valid,
    input  wire ev_snap_t             snap,
    output logic                      snap_ready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int AW  = $clog2(CHANNELS > 1 ? CHANNELS : 2);
    localparam int DW  = ((17 + FRAC_BITS) > 33 ? (17 + FRAC_BITS) : 33) + 1;
    localparam int DHW = DW - FRAC_BITS;
    localparam int PHW = DHW + 32;
    localparam int PLW = FRAC_BITS + 33;
    localparam int LPW = 49;
    localparam int LSW = 50;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v[63:31] == {33{v[63]}}) begin
            r = v[31:0];
        end else if (v[63]) begin
            r = 32'h8000_0000;
        end else begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic [4:0] chan_code(input det_snap_t s);
        return s.single ? {1'b0, s.ch} : CHAN_NONE;
    endfunction

    logic en_a, en_b, en_c, en_d;

    logic     a_v_reg, b_v_reg, c_v_reg, d_v_reg;
    ev_snap_t a_snap_reg, b_snap_reg, c_snap_reg;

    logic signed [31:0] x_off_rd, x_gain_rd, y_off_rd, y_gain_rd, ped_rd, e_gain_rd;

    logic signed [LPW-1:0]     x_prod_reg, y_prod_reg;
    logic signed [31:0]        x_off_reg, y_off_reg, e_gain_reg;
    logic signed [DHW-1:0]     e_dh_reg;
    logic [FRAC_BITS-1:0]      e_dl_reg;
    logic signed [LSW-1:0]     x_sum_reg, y_sum_reg;
    logic signed [PHW-1:0]     e_ph_reg;
    logic signed [PLW-1:0]     e_pl_reg;
    logic [M_TDATA_W-1:0]      m_tdata_reg;

    logic signed [LPW-1:0]     x_prod_next, y_prod_next;
    logic signed [DW-1:0]      e_d_next;
    logic signed [63:0]        e_sum;
    logic [M_TDATA_W-1:0]      m_tdata_next;

    // stall chain, back from the output register
    assign en_d       = !d_v_reg || m_tready;
    assign en_c       = !c_v_reg || en_d;
    assign en_b       = !b_v_reg || en_c;
    assign en_a       = !a_v_reg || en_b;
    assign snap_ready = en_a;

    // calibration tables, read at the hit channel as the snapshot enters
    shsc_ram #(.DEPTH(CHANNELS), .WIDTH(32)) u_x_off_ram (
        .aclk(aclk), .wr_en(tbl_wr.en && (tbl_wr.sel == TBL_X_OFFSET)),
        .wr_addr(AW'(tbl_wr.ch)), .wr_data(tbl_wr.word),
        .rd_en(en_a), .rd_addr(AW'(snap.x.ch)), .rd_data(x_off_rd)
    );
    shsc_ram #(.DEPTH(CHANNELS), .WIDTH(32)) u_x_gain_ram (
        .aclk(aclk), .wr_en(tbl_wr.en && (tbl_wr.sel == TBL_X_GAIN)),
        .wr_addr(AW'(tbl_wr.ch)), .wr_data(tbl_wr.word),
        .rd_en(en_a), .rd_addr(AW'(snap.x.ch)), .rd_data(x_gain_rd)
    );
    shsc_ram #(.DEPTH(CHANNELS), .WIDTH(32)) u_y_off_ram (
        .aclk(aclk), .wr_en(tbl_wr.en && (tbl_wr.sel == TBL_Y_OFFSET)),
        .wr_addr(AW'(tbl_wr.ch)), .wr_data(tbl_wr.word),
        .rd_en(en_a), .rd_addr(AW'(snap.y.ch)), .rd_data(y_off_rd)
    );
    shsc_ram #(.DEPTH(CHANNELS), .WIDTH(32)) u_y_gain_ram (
        .aclk(aclk), .wr_en(tbl_wr.en && (tbl_wr.sel == TBL_Y_GAIN)),
        .wr_addr(AW'(tbl_wr.ch)), .wr_data(tbl_wr.word),
        .rd_en(en_a), .rd_addr(AW'(snap.y.ch)), .rd_data(y_gain_rd)
    );
    shsc_ram #(.DEPTH(CHANNELS), .WIDTH(32)) u_ped_ram (
        .aclk(aclk), .wr_en(tbl_wr.en && (tbl_wr.sel == TBL_PEDESTAL)),
        .wr_addr(AW'(tbl_wr.ch)), .wr_data(tbl_wr.word),
        .rd_en(en_a), .rd_addr(AW'(snap.e.ch)), .rd_data(ped_rd)
    );
    shsc_ram #(.DEPTH(CHANNELS), .WIDTH(32)) u_e_gain_ram (
        .aclk(aclk), .wr_en(tbl_wr.en && (tbl_wr.sel == TBL_E_GAIN)),
        .wr_addr(AW'(tbl_wr.ch)), .wr_data(tbl_wr.word),
        .rd_en(en_a), .rd_addr(AW'(snap.e.ch)), .rd_data(e_gain_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
        end else begin
            if (en_a) a_v_reg <= snap_valid;
            if (en_b) b_v_reg <= a_v_reg;
            if (en_c) c_v_reg <= b_v_reg;
            if (en_d) d_v_reg <= c_v_reg;
        end
    end

    // stage A: snapshot beside the table read data
    always_ff @(posedge aclk) begin
        if (en_a) begin
            a_snap_reg <= snap;
        end
    end

    // stage B: linear products, energy difference split at the binary point
    assign x_prod_next = LPW'($signed({1'b0, a_snap_reg.x.amp})) * LPW'(x_gain_rd);
    assign y_prod_next = LPW'($signed({1'b0, a_snap_reg.y.amp})) * LPW'(y_gain_rd);
    assign e_d_next    = $signed(DW'({a_snap_reg.e.amp, {FRAC_BITS{1'b0}}})) - DW'(ped_rd);

    always_ff @(posedge aclk) begin
        if (en_b) begin
            b_snap_reg <= a_snap_reg;
            x_prod_reg <= x_prod_next;
            x_off_reg  <= x_off_rd;
            y_prod_reg <= y_prod_next;
            y_off_reg  <= y_off_rd;
            e_dh_reg   <= e_d_next[DW-1:FRAC_BITS];
            e_dl_reg   <= e_d_next[FRAC_BITS-1:0];
            e_gain_reg <= e_gain_rd;
        end
    end

    // stage C: add offsets, multiply both energy halves by the gain
    always_ff @(posedge aclk) begin
        if (en_c) begin
            c_snap_reg <= b_snap_reg;
            x_sum_reg  <= LSW'(x_prod_reg) + LSW'(x_off_reg);
            y_sum_reg  <= LSW'(y_prod_reg) + LSW'(y_off_reg);
            e_ph_reg   <= PHW'(e_dh_reg) * PHW'(e_gain_reg);
            e_pl_reg   <= PLW'($signed({1'b0, e_dl_reg})) * PLW'(e_gain_reg);
        end
    end

    // stage D: floor the fractional part, saturate, pack
    assign e_sum = 64'(e_ph_reg) + 64'(e_pl_reg >>> FRAC_BITS);

    always_comb begin
        m_tdata_next = {
            1'b0,
            c_snap_reg.e.single ? sat32(e_sum) : 32'd0,
            c_snap_reg.e.single ? c_snap_reg.e.amp : 16'd0,
            chan_code(c_snap_reg.e),
            c_snap_reg.y.single ? sat32(64'(y_sum_reg)) : 32'd0,
            c_snap_reg.y.single ? c_snap_reg.y.amp : 16'd0,
            chan_code(c_snap_reg.y),
            c_snap_reg.x.single ? sat32(64'(x_sum_reg)) : 32'd0,
            chan_code(c_snap_reg.x)
        };
    end

    always_ff @(posedge aclk) begin
        if (en_d) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = d_v_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

// File: tb/single_hit_strip_calibrator_test.sv
`timescale 1ns / 100ps

module single_hit_strip_calibrator_test;
    import shsc_pkg::*;

    localparam int CHANNELS     = 16;
    localparam int FRAC_BITS    = 16;
    localparam int IDLE_PCT     = 38;      // chance in a hundred that a side idles a cycle
    localparam int DRAIN_CYCLES = 10;      // result pipeline is four deep; leave margin
    localparam int PHASE_ITEMS  = 320;
    localparam int CYCLE_LIMIT  = 200000;

    // codes that match no detector or table: no hit and no table write
    localparam logic [1:0] DET_UNUSED = 2'd3;
    localparam logic [2:0] TBL_UNUSED = 3'd7;

    localparam logic [15:0] Y_THRESHOLD_DEFAULT [CHANNELS] = '{
        16'd80, 16'd103, 16'd81, 16'd106, 16'd105, 16'd112, 16'd97, 16'd108,
        16'd111, 16'd116, 16'd116, 16'd110, 16'd110, 16'd113, 16'd98, 16'd99
    };

    localparam logic signed [95:0] SAT_HI = 96'sh7FFF_FFFF;
    localparam logic signed [95:0] SAT_LO = -96'sh8000_0000;

    typedef struct {
        logic        op;
        logic [2:0]  sel;
        logic [1:0]  det;
        logic [3:0]  ch;
        logic [15:0] amp;
        logic [31:0] word;
        logic        last;
    } request_t;

    // m_tdata layout, highest field first
    typedef struct packed {
        logic        pad;
        logic [31:0] e_energy;
        logic [15:0] e_amplitude;
        logic [4:0]  e_channel;
        logic [31:0] y_position;
        logic [15:0] y_amplitude;
        logic [4:0]  y_channel;
        logic [31:0] x_position;
        logic [4:0]  x_channel;
    } event_result_t;

    // Tracks thresholds, calibration tables and per-detector hit state; queues the
    // expected report for every closing sample and checks reports in order.
    class strip_event_scoreboard;
        logic [15:0]        x_threshold;
        logic [15:0]        energy_threshold;
        logic signed [31:0] x_offset [CHANNELS];
        logic signed [31:0] x_gain [CHANNELS];
        logic signed [31:0] y_offset [CHANNELS];
        logic signed [31:0] y_gain [CHANNELS];
        logic signed [31:0] pedestal [CHANNELS];
        logic signed [31:0] e_gain [CHANNELS];
        logic [15:0]        y_threshold [CHANNELS];
        logic [1:0]         hit_count [3];
        logic [3:0]         hit_channel [3];
        logic [15:0]        hit_amplitude [3];
        event_result_t      pending_events [$];
        int                 mismatches;

        function new();
            x_threshold      = 16'd0;
            energy_threshold = 16'd150;
            for (int i = 0; i < CHANNELS; i++) begin
                x_offset[i]    = '0;
                x_gain[i]      = '0;
                y_offset[i]    = '0;
                y_gain[i]      = '0;
                pedestal[i]    = '0;
                e_gain[i]      = '0;
                y_threshold[i] = Y_THRESHOLD_DEFAULT[i];
            end
            clear_event();
            mismatches = 0;
        endfunction

        function void clear_event();
            for (int d = 0; d < 3; d++) begin
                hit_count[d]     = '0;
                hit_channel[d]   = '0;
                hit_amplitude[d] = '0;
            end
        endfunction

        function void set_register(logic [CFG_ADDR_W-1:0] idx, logic [15:0] value);
            case (idx)
                REG_X_THRESHOLD:      x_threshold = value;
                REG_ENERGY_THRESHOLD: energy_threshold = value;
                default: ;
            endcase
        endfunction

        function logic [31:0] clamp32(logic signed [95:0] v);
            if (v > SAT_HI) return 32'h7FFF_FFFF;
            if (v < SAT_LO) return 32'h8000_0000;
            return v[31:0];
        endfunction

        function logic [31:0] calibrated_position(logic [15:0] amp, logic signed [31:0] gain,
                                                  logic signed [31:0] offset);
            return clamp32(longint'(amp) * longint'(gain) + longint'(offset));
        endfunction

        // (amp - pedestal) * gain, floored back to the fixed-point grid
        function logic [31:0] calibrated_energy(logic [15:0] amp, logic signed [31:0] ped,
                                                logic signed [31:0] gain);
            longint             diff;
            logic signed [95:0] scaled;
            diff   = (longint'(amp) <<< FRAC_BITS) - longint'(ped);
            scaled = diff;
            scaled = (scaled * gain) >>> FRAC_BITS;
            return clamp32(scaled);
        endfunction

        function void note_request(request_t r);
            logic          hit;
            event_result_t res;
            logic [3:0]    c;
            if (r.op == OP_WRITE) begin
                case (r.sel)
                    TBL_X_OFFSET:    x_offset[r.ch] = r.word;
                    TBL_X_GAIN:      x_gain[r.ch] = r.word;
                    TBL_Y_OFFSET:    y_offset[r.ch] = r.word;
                    TBL_Y_GAIN:      y_gain[r.ch] = r.word;
                    TBL_Y_THRESHOLD: y_threshold[r.ch] = r.word[15:0];
                    TBL_PEDESTAL:    pedestal[r.ch] = r.word;
                    TBL_E_GAIN:      e_gain[r.ch] = r.word;
                    default: ;
                endcase
                return;
            end
            case (r.det)
                DET_X:   hit = r.amp > x_threshold;
                DET_Y:   hit = r.amp > y_threshold[r.ch];
                DET_E:   hit = r.amp > energy_threshold;
                default: hit = 1'b0;
            endcase
            if (hit) begin
                if (hit_count[r.det] < 2) hit_count[r.det]++;
                hit_channel[r.det]   = r.ch;
                hit_amplitude[r.det] = r.amp;
            end
            if (!r.last) return;
            res = '0;
            res.x_channel = CHAN_NONE;
            res.y_channel = CHAN_NONE;
            res.e_channel = CHAN_NONE;
            if (hit_count[DET_X] == 1) begin
                c = hit_channel[DET_X];
                res.x_channel  = {1'b0, c};
                res.x_position = calibrated_position(hit_amplitude[DET_X], x_gain[c], x_offset[c]);
            end
            if (hit_count[DET_Y] == 1) begin
                c = hit_channel[DET_Y];
                res.y_channel   = {1'b0, c};
                res.y_amplitude = hit_amplitude[DET_Y];
                res.y_position  = calibrated_position(hit_amplitude[DET_Y], y_gain[c], y_offset[c]);
            end
            if (hit_count[DET_E] == 1) begin
                c = hit_channel[DET_E];
                res.e_channel   = {1'b0, c};
                res.e_amplitude = hit_amplitude[DET_E];
                res.e_energy    = calibrated_energy(hit_amplitude[DET_E], pedestal[c], e_gain[c]);
            end
            pending_events.push_back(res);
            clear_event();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            event_result_t got;
            event_result_t want;
            got = data;
            if (pending_events.size() == 0) begin
                $error("event report with no closing sample pending: %h", data);
                mismatches++;
                return;
            end
            want = pending_events.pop_front();
            compare_field("x_channel", want.x_channel, got.x_channel);
            compare_field("x_position", want.x_position, got.x_position);
            compare_field("y_channel", want.y_channel, got.y_channel);
            compare_field("y_amplitude", want.y_amplitude, got.y_amplitude);
            compare_field("y_position", want.y_position, got.y_position);
            compare_field("e_channel", want.e_channel, got.e_channel);
            compare_field("e_amplitude", want.e_amplitude, got.e_amplitude);
            compare_field("e_energy", want.e_energy, got.e_energy);
        endfunction
    endclass

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;   // channel, amplitude, table_word, zero pad
    logic [S_TUSER_W-1:0]  s_tuser     = '0;   // op, table_select, detector
    logic                  s_tlast     = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    strip_event_scoreboard calib_sb;
    bit                    steady      = 1'b0;  // high: neither side idles
    int                    sent_items  = 0;
    int                    cycle_count = 0;

    single_hit_strip_calibrator #(
        .CHANNELS  (CHANNELS),
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL single_hit_strip_calibrator");
            $finish;
        end
    end

    // Result side: check every accepted report, then pick next cycle's ready at random
    // (always ready while the steady stretch runs).
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) calib_sb.check_result(m_tdata);
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic request_t table_write(logic [2:0] sel, logic [3:0] ch, logic [31:0] word,
                                             logic last = 1'b0);
        request_t r;
        r.op   = OP_WRITE;
        r.sel  = sel;
        r.det  = 2'($urandom);      // ignored on writes; randomize to exercise the bits
        r.ch   = ch;
        r.amp  = 16'($urandom);
        r.word = word;
        r.last = last;
        return r;
    endfunction

    function automatic request_t strip_sample(logic [1:0] det, logic [3:0] ch, logic [15:0] amp,
                                              logic last);
        request_t r;
        r.op   = OP_SAMPLE;
        r.sel  = 3'($urandom);
        r.det  = det;
        r.ch   = ch;
        r.amp  = amp;
        r.word = $urandom;
        r.last = last;
        return r;
    endfunction

    // Mostly small signed Q16.16 values, with the extremes and raw noise mixed in.
    function automatic logic [31:0] random_table_word();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom;
            default: return 32'($urandom_range(8 << 16)) - 32'(4 << 16);
        endcase
    endfunction

    // Only the low half counts; keep the upper half random to prove it is dropped.
    function automatic logic [31:0] random_threshold_word();
        case ($urandom_range(9))
            0:       return {16'($urandom), 16'h0000};
            1:       return {16'($urandom), 16'hFFFF};
            2:       return $urandom;
            default: return {16'($urandom), 16'($urandom_range(300, 40))};
        endcase
    endfunction

    // Bias amplitudes around the live threshold so single hits are common.
    function automatic logic [15:0] pick_amplitude(logic [1:0] det, logic [3:0] ch);
        logic [15:0] thr;
        int          roll;
        case (det)
            DET_X:   thr = calib_sb.x_threshold;
            DET_Y:   thr = calib_sb.y_threshold[ch];
            DET_E:   thr = calib_sb.energy_threshold;
            default: thr = 16'($urandom);
        endcase
        roll = $urandom_range(99);
        if (roll < 40) return (thr == 16'hFFFF) ? thr : 16'($urandom_range(65535, int'(thr) + 1));
        if (roll < 85) return 16'($urandom_range(int'(thr), 0));
        if (roll < 90) return 16'h0000;
        if (roll < 95) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // Present one request, idling at random first; return once it has been taken.
    task automatic send_request(input request_t r);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {r.det, r.sel, r.op};
        s_tdata  <= {4'b0, r.word, r.amp, r.ch};
        s_tlast  <= r.last;
        do @(posedge aclk); while (!s_tready);
        calib_sb.note_request(r);
        sent_items++;
    endtask

    // Hold the input until every report is in, then let trailing table writes settle.
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (calib_sb.pending_events.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_thresholds(logic [15:0] x_thr, logic [15:0] e_thr);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= REG_X_THRESHOLD;
        cfg_wr_data <= x_thr;
        @(posedge aclk);
        cfg_addr    <= REG_ENERGY_THRESHOLD;
        cfg_wr_data <= e_thr;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        calib_sb.set_register(REG_X_THRESHOLD, x_thr);
        calib_sb.set_register(REG_ENERGY_THRESHOLD, e_thr);
    endtask

    // Fill every gain, offset and pedestal entry before any sample can read one.
    // Channel 0 gets the largest word and the last channel the most negative,
    // so the directed events below hit both saturation limits.
    task automatic load_tables();
        logic [31:0] word;
        for (int sel = TBL_X_OFFSET; sel <= TBL_E_GAIN; sel++) begin
            if (sel == TBL_Y_THRESHOLD) continue;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                if (ch == 0)
                    word = 32'h7FFF_FFFF;
                else if (ch == CHANNELS - 1)
                    word = 32'h8000_0000;
                else
                    word = random_table_word();
                send_request(table_write(3'(sel), 4'(ch), word));
            end
        end
    endtask

    task automatic send_directed();
        // one hit per detector on the extreme channels, X and Y at full scale: saturated results
        send_request(strip_sample(DET_X, 4'd0, 16'hFFFF, 1'b0));
        send_request(strip_sample(DET_Y, 4'd15, 16'hFFFF, 1'b0));
        send_request(strip_sample(DET_E, 4'd0, 16'd151, 1'b1));
        // amplitude equal to a threshold is no hit; zero never beats a zero threshold
        send_request(strip_sample(DET_X, 4'd15, 16'd1, 1'b0));
        send_request(strip_sample(DET_Y, 4'd0, 16'd80, 1'b0));
        send_request(strip_sample(DET_E, 4'd15, 16'd150, 1'b0));
        send_request(strip_sample(DET_X, 4'd4, 16'd0, 1'b1));
        // unknown detector closes an event with no hits
        send_request(strip_sample(DET_UNUSED, 4'd7, 16'hFFFF, 1'b1));
        // same channel twice gives multiplicity two; a write marked last and an
        // unknown table select inside the event change nothing
        send_request(strip_sample(DET_X, 4'd3, 16'd500, 1'b0));
        send_request(table_write(TBL_UNUSED, 4'd3, 32'hFFFF_FFFF, 1'b1));
        send_request(strip_sample(DET_X, 4'd3, 16'd600, 1'b0));
        send_request(strip_sample(DET_Y, 4'd5, 16'd113, 1'b1));
        // energy count stops at two after three hits
        send_request(strip_sample(DET_E, 4'd1, 16'd200, 1'b0));
        send_request(strip_sample(DET_E, 4'd2, 16'd300, 1'b0));
        send_request(strip_sample(DET_E, 4'd3, 16'd400, 1'b0));
        send_request(strip_sample(DET_Y, 4'd2, 16'd81, 1'b1));
        // threshold write keeps the low half only (40 here)
        send_request(table_write(TBL_Y_THRESHOLD, 4'd6, 32'h1234_0028));
        send_request(strip_sample(DET_Y, 4'd6, 16'd41, 1'b1));
        send_request(strip_sample(DET_Y, 4'd6, 16'd40, 1'b1));
        // a real hit followed by an unknown-detector close still reports
        send_request(strip_sample(DET_Y, 4'd9, 16'd200, 1'b0));
        send_request(strip_sample(DET_UNUSED, 4'd2, 16'd0, 1'b1));
    endtask

    task automatic send_random_table_write();
        logic [2:0] sel;
        sel = 3'($urandom);
        send_request(table_write(sel, 4'($urandom),
                                 (sel == TBL_Y_THRESHOLD) ? random_threshold_word()
                                                          : random_table_word(),
                                 1'($urandom)));
    endtask

    // One event: a few samples, the last one marked, with stray table writes and
    // unknown-detector samples mixed in.
    task automatic send_random_event();
        int         samples;
        logic [1:0] det;
        logic [3:0] ch;
        samples = $urandom_range(6, 1);
        for (int i = 0; i < samples; i++) begin
            if ($urandom_range(99) < 8) send_random_table_write();
            det = ($urandom_range(99) < 5) ? DET_UNUSED : 2'($urandom_range(2));
            ch  = 4'($urandom);
            send_request(strip_sample(det, ch, pick_amplitude(det, ch), i == samples - 1));
        end
    endtask

    task automatic run_phase(logic [15:0] x_thr, logic [15:0] e_thr, int items, int steady_items);
        int start;
        drain_pipeline();
        set_thresholds(x_thr, e_thr);
        start  = sent_items;
        steady = (steady_items > 0);
        while (sent_items < start + items) begin
            if (sent_items >= start + steady_items) steady = 1'b0;
            send_random_event();
        end
        steady = 1'b0;
    endtask

    initial begin
        calib_sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_tables();
        send_directed();

        // X can never hit, every nonzero energy sample hits; start with no idling
        run_phase(16'hFFFF, 16'd0, PHASE_ITEMS, 150);
        // low random X threshold, energy can never hit
        run_phase(16'($urandom_range(4000)), 16'hFFFF, PHASE_ITEMS, 0);
        // back to the reset values
        run_phase(16'd0, 16'd150, PHASE_ITEMS, 0);

        drain_pipeline();
        if (calib_sb.mismatches == 0) begin
            $display("PASS single_hit_strip_calibrator");
        end else begin
            $display("FAIL single_hit_strip_calibrator");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/shsc_pkg.sv
hw/rtl/shsc_ram.sv
hw/rtl/shsc_hit.sv
hw/rtl/shsc_cal.sv
hw/rtl/single_hit_strip_calibrator.sv
tb/single_hit_strip_calibrator_test.sv
